### rtl/dcfr_pkg.sv
// shared constants and result type for the daisy-chain frame receiver
package dcfr_pkg;

  localparam int MaxLeds = 64;
  localparam int IdxW    = $clog2(MaxLeds);
  localparam int CntW    = IdxW + 1;

  localparam logic [7:0] SYNC_BYTE = 8'h7E;
  localparam logic [7:0] MY_ADDR   = 8'h80;
  localparam logic [7:0] PAD_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_BYTE  = 8'h7F;
  localparam logic [7:0] ESC_ADD   = 8'h4E;

  localparam logic [CntW-1:0] COUNT_RESET = CntW'(28);

  typedef struct packed {
    logic            tx_valid;
    logic [7:0]      tx_byte;
    logic            store_valid;
    logic [IdxW-1:0] store_index;
    logic [7:0]      store_value;
    logic            frame_done;
  } dcfr_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } dcfr_byte_t;

  // clamp the configured count to 1..MaxLeds
  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = n;
    if (n == '0) begin
      r = CntW'(1);
    end else if (n > CntW'(MaxLeds)) begin
      r = CntW'(MaxLeds);
    end
    return r;
  endfunction

endpackage

### rtl/dcfr_in_reg.sv
// input register stage for received bytes
module dcfr_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              advance,
  output dcfr_pkg::dcfr_byte_t held
);

  logic       valid_r;
  logic [7:0] byte_r;

  // hold while the core cannot take the registered byte
  assign in_stall = valid_r && !advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign held.valid   = valid_r;
  assign held.rx_byte = byte_r;

endmodule

### rtl/dcfr_core.sv
// receiver state machine and result register
module dcfr_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dcfr_pkg::dcfr_byte_t       held,
  input  logic [dcfr_pkg::CntW-1:0]  led_count,
  output logic                       advance,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dcfr_pkg::dcfr_result_t     result
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_DATA = 3'd2,
    PH_ESC  = 3'd3,
    PH_FWD  = 3'd4
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [dcfr_pkg::CntW-1:0]   index_r, index_nxt;
  logic                        out_valid_r;
  dcfr_pkg::dcfr_result_t      res_r, res_nxt;
  logic [dcfr_pkg::CntW-1:0]   index_inc;
  logic [dcfr_pkg::CntW-1:0]   limit;
  logic                        last_store;
  logic [7:0]                  b;

  // result register free or being drained this cycle
  assign advance = !out_valid_r || !out_stall;

  assign b          = held.rx_byte;
  assign limit      = dcfr_pkg::clamp_count(led_count);
  assign index_inc  = index_r + dcfr_pkg::CntW'(1);
  assign last_store = index_inc >= limit;

  // next state and result for the byte in the input register
  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    res_nxt   = '0;
    unique case (phase_r)
      PH_ADDR: begin
        if (b == dcfr_pkg::MY_ADDR) begin
          phase_nxt = PH_DATA;
          index_nxt = '0;
        end else if (b > dcfr_pkg::MY_ADDR) begin
          phase_nxt        = PH_FWD;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = b - 8'd1;
        end
      end
      PH_DATA, PH_ESC: begin
        if (phase_r == PH_DATA && b == dcfr_pkg::PAD_BYTE) begin
          phase_nxt = PH_DATA;
        end else if (phase_r == PH_DATA && b == dcfr_pkg::ESC_BYTE) begin
          phase_nxt = PH_ESC;
        end else begin
          res_nxt.store_valid = 1'b1;
          res_nxt.store_index = index_r[dcfr_pkg::IdxW-1:0];
          res_nxt.store_value = (phase_r == PH_ESC) ? b + dcfr_pkg::ESC_ADD : b;
          index_nxt           = index_inc;
          if (last_store) begin
            phase_nxt          = PH_FWD;
            res_nxt.tx_valid   = 1'b1;
            res_nxt.tx_byte    = dcfr_pkg::MY_ADDR;
            res_nxt.frame_done = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_FWD: begin
        if (b == dcfr_pkg::SYNC_BYTE) begin
          phase_nxt = PH_ADDR;
        end
        res_nxt.tx_valid = 1'b1;
        res_nxt.tx_byte  = b;
      end
      default: begin
        if (b == dcfr_pkg::SYNC_BYTE) begin
          phase_nxt        = PH_ADDR;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = dcfr_pkg::SYNC_BYTE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      index_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= held.valid;
      if (held.valid) begin
        phase_r <= phase_nxt;
        index_r <= index_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && held.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

### rtl/daisy_chain_frame_receiver_unit.sv
// top level of the daisy-chain frame receiver
// One received byte is taken per clock cycle when the result side keeps up; each byte gives
// exactly one result, registered first in the input register and then in the result
// register, with the phase/index update and result decode between them.
// Throughput is bounded only by the result channel's stall. led_count is clamped to 1..64
// and must be written while no byte is in flight; its reset value is 28.
module daisy_chain_frame_receiver_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dcfr_pkg::CntW-1:0]       cfg_led_count,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_tx_valid,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_store_valid,
  output logic [dcfr_pkg::IdxW-1:0]       out_store_index,
  output logic [7:0]                      out_store_value,
  output logic                            out_frame_done
);

  logic [dcfr_pkg::CntW-1:0] led_count_r;
  logic                      advance;
  dcfr_pkg::dcfr_byte_t      held;
  dcfr_pkg::dcfr_result_t    result;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= dcfr_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      led_count_r <= cfg_led_count;
    end
  end

  // input register
  dcfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .held       (held)
  );

  // receiver core
  dcfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .led_count (led_count_r),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_tx_valid    = result.tx_valid;
  assign out_tx_byte     = result.tx_byte;
  assign out_store_valid = result.store_valid;
  assign out_store_index = result.store_index;
  assign out_store_value = result.store_value;
  assign out_frame_done  = result.frame_done;

  // frame end always stores a value and sends the claim byte downstream
  a_done_sends_claim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |->
      out_store_valid && out_tx_valid && out_tx_byte == dcfr_pkg::MY_ADDR)
    else $error("frame end without store and claim byte");

  // a new result only follows a byte held in the input register
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(held.valid))
    else $error("result appeared without a received byte");

  // an idle transmit slot carries zero
  a_tx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00)
    else $error("tx byte not cleared when no transmit");

endmodule

### sim/testbench.sv
// self-checking testbench for the daisy-chain frame receiver unit
module testbench;

  typedef enum logic [2:0] {
    RX_IDLE = 3'd0,
    RX_ADDR = 3'd1,
    RX_DATA = 3'd2,
    RX_ESC  = 3'd3,
    RX_FWD  = 3'd4
  } rx_phase_t;

  typedef enum int {
    STALL_NONE,
    STALL_PATTERN,
    STALL_RANDOM
  } stall_mode_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [dcfr_pkg::CntW-1:0] cfg_led_count;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_rx_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_tx_valid;
  logic [7:0]                out_tx_byte;
  logic                      out_store_valid;
  logic [dcfr_pkg::IdxW-1:0] out_store_index;
  logic [7:0]                out_store_value;
  logic                      out_frame_done;

  // receiver state mirrored by the predictor
  rx_phase_t                 rx_phase;
  int                        rx_index;
  logic [dcfr_pkg::CntW-1:0] led_count_setting;

  dcfr_pkg::dcfr_result_t    frame_results_q[$];
  int                        errors;
  int                        bytes_sent;

  // sender and receiver idling controls
  bit                        gaps_on;
  int                        burst_left;
  stall_mode_t               stall_mode;
  int                        hold_left;

  daisy_chain_frame_receiver_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_led_count   (cfg_led_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tx_valid    (out_tx_valid),
    .out_tx_byte     (out_tx_byte),
    .out_store_valid (out_store_valid),
    .out_store_index (out_store_index),
    .out_store_value (out_store_value),
    .out_frame_done  (out_frame_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("daisy_chain_frame_receiver_unit regression: fail");
    $finish;
  end

  // expected result of one received byte, advancing the mirrored state
  function automatic dcfr_pkg::dcfr_result_t advance_receiver(input logic [7:0] b);
    dcfr_pkg::dcfr_result_t r;
    logic [7:0]             v;
    logic                   take;
    int                     limit;
    r     = '0;
    v     = b;
    take  = 1'b0;
    limit = int'(led_count_setting);
    if (limit < 1) limit = 1;
    if (limit > dcfr_pkg::MaxLeds) limit = dcfr_pkg::MaxLeds;
    case (rx_phase)
      RX_ADDR: begin
        if (b == dcfr_pkg::MY_ADDR) begin
          rx_phase = RX_DATA;
          rx_index = 0;
        end else if (b > dcfr_pkg::MY_ADDR) begin
          rx_phase   = RX_FWD;
          r.tx_valid = 1'b1;
          r.tx_byte  = b - 8'd1;
        end
      end
      RX_DATA: begin
        if (b == dcfr_pkg::ESC_BYTE) rx_phase = RX_ESC;
        else if (b != dcfr_pkg::PAD_BYTE) take = 1'b1;
      end
      RX_ESC: begin
        take     = 1'b1;
        v        = b + dcfr_pkg::ESC_ADD;
        rx_phase = RX_DATA;
      end
      RX_FWD: begin
        if (b == dcfr_pkg::SYNC_BYTE) rx_phase = RX_ADDR;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
      end
      default: begin
        if (b == dcfr_pkg::SYNC_BYTE) begin
          rx_phase   = RX_ADDR;
          r.tx_valid = 1'b1;
          r.tx_byte  = dcfr_pkg::SYNC_BYTE;
        end
      end
    endcase
    // brightness store, ending the frame once the count is reached
    if (take) begin
      r.store_valid = 1'b1;
      r.store_index = rx_index[dcfr_pkg::IdxW-1:0];
      r.store_value = v;
      rx_index      = rx_index + 1;
      if (rx_index >= limit) begin
        rx_phase     = RX_FWD;
        r.tx_valid   = 1'b1;
        r.tx_byte    = dcfr_pkg::MY_ADDR;
        r.frame_done = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // offer one byte, in bursts with random gaps when gaps are on, and wait for its transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    frame_results_q.push_back(advance_receiver(b));
    bytes_sent++;
  endtask

  // let the block drain, then write the count register
  task automatic write_count(input logic [dcfr_pkg::CntW-1:0] n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_led_count <= n;
    @(negedge clk);
    cfg_wr_en         <= 1'b0;
    led_count_setting  = n;
  endtask

  // well-formed frames with random content, mixed with noise
  task automatic send_random_frames(input int n_bytes);
    int target;
    int pick;
    int k;
    int limit;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick  = $urandom_range(0, 99);
      limit = int'(led_count_setting);
      if (limit < 1) limit = 1;
      if (limit > dcfr_pkg::MaxLeds) limit = dcfr_pkg::MaxLeds;
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(dcfr_pkg::SYNC_BYTE);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // address for a node further down the chain
          send_byte(8'($urandom_range(8'h81, 8'hFF)));
          repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          if (pick < 25) send_byte(8'($urandom_range(8'h00, 8'h7F)));
          send_byte(dcfr_pkg::MY_ADDR);
          for (k = 0; k < limit; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
              send_byte(dcfr_pkg::PAD_BYTE);
              send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 25) begin
              send_byte(dcfr_pkg::ESC_BYTE);
              send_byte(8'($urandom_range(0, 255)));
            end else begin
              send_byte(8'($urandom_range(0, 255)));
            end
          end
          repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // idle-phase noise, sync echo, low and forwarded addresses, sync in forward
  task automatic test_idle_and_address();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dcfr_pkg::SYNC_BYTE);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(dcfr_pkg::SYNC_BYTE);
    send_byte(8'h81);
    send_byte(dcfr_pkg::SYNC_BYTE);
  endtask

  // claimed frame with pad, escapes that wrap, end of frame and forwarding
  task automatic test_claimed_frame();
    write_count(dcfr_pkg::CntW'(3));
    stall_mode = STALL_RANDOM;
    send_byte(dcfr_pkg::MY_ADDR);
    send_byte(dcfr_pkg::PAD_BYTE);
    send_byte(8'h00);
    send_byte(dcfr_pkg::ESC_BYTE);
    send_byte(8'hB2);
    send_byte(dcfr_pkg::ESC_BYTE);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(dcfr_pkg::SYNC_BYTE);
  endtask

  // count lowered while a frame is partly received
  task automatic test_count_lowered_mid_frame();
    write_count(dcfr_pkg::CntW'(10));
    send_byte(dcfr_pkg::MY_ADDR);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    write_count(dcfr_pkg::CntW'(2));
    send_byte(8'hAA);
    send_byte(8'h5A);
  endtask

  // zero, one, the maximum and above the maximum
  task automatic test_count_extremes();
    gaps_on    = 1'b1;
    stall_mode = STALL_PATTERN;
    write_count(dcfr_pkg::CntW'(0));
    send_random_frames(80);
    write_count(dcfr_pkg::CntW'(1));
    send_random_frames(80);
    write_count(dcfr_pkg::CntW'(dcfr_pkg::MaxLeds));
    send_random_frames(200);
    write_count(7'h7F);
    send_random_frames(150);
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    write_count(dcfr_pkg::CntW'(6));
    hold_left = 300;
    send_random_frames(60);
  endtask

  // mixed traffic over several counts and idling styles
  task automatic test_random_traffic();
    int k;
    write_count(dcfr_pkg::COUNT_RESET);
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    send_random_frames(250);
    for (k = 0; k < 10; k++) begin
      write_count(dcfr_pkg::CntW'($urandom_range(1, 12)));
      gaps_on    = ($urandom_range(0, 2) != 0);
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      send_random_frames(100);
    end
  endtask

  // result side: stall pattern, random stalls and hold-off
  initial begin
    logic [15:0] stall_pat;
    int          pat_age;
    logic        stall_next;
    out_stall = 1'b0;
    stall_pat = 16'($urandom);
    pat_age   = 0;
    forever begin
      @(negedge clk);
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          STALL_PATTERN: begin
            stall_next = stall_pat[0];
            stall_pat  = {stall_pat[0], stall_pat[15:1]};
            pat_age++;
            if (pat_age == 64) begin
              stall_pat = 16'($urandom);
              pat_age   = 0;
            end
          end
          STALL_RANDOM: stall_next = ($urandom_range(0, 99) < 40);
          default:      stall_next = 1'b0;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // compare each result transfer with the oldest expectation
  initial begin
    dcfr_pkg::dcfr_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(out_tx_valid));
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("store_valid", 8'(want.store_valid), 8'(out_store_valid));
          check_field("store_index", 8'(want.store_index), 8'(out_store_index));
          check_field("store_value", want.store_value, out_store_value);
          check_field("frame_done", 8'(want.frame_done), 8'(out_frame_done));
        end
      end
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_led_count     = '0;
    in_valid          = 1'b0;
    in_rx_byte        = 8'h00;
    errors            = 0;
    bytes_sent        = 0;
    gaps_on           = 1'b0;
    burst_left        = 0;
    stall_mode        = STALL_NONE;
    hold_left         = 0;
    rx_phase          = RX_IDLE;
    rx_index          = 0;
    led_count_setting = dcfr_pkg::COUNT_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_address();
    test_claimed_frame();
    test_count_lowered_mid_frame();
    test_count_extremes();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("daisy_chain_frame_receiver_unit regression: pass");
    end else begin
      $display("daisy_chain_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
